// ===== rtl/dagt_pkg.sv =====
// Shared definitions for the dependency-graph enable tracker.
// Action and status codes, field widths and the default node count.
// No dependencies.
package dagt_pkg;

   // Field widths of the request and response channels
   localparam int ACTION_W = 3;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 3;
   localparam int MASK_W   = 16;

   // Default graph size
   localparam int DEFAULT_NODE_COUNT = 16;

   // Request actions; unused codes act as a read
   localparam logic [ACTION_W-1:0] ACT_ADD_NODE = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD_EDGE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_ENABLE   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DISABLE  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_TOGGLE   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_READ     = 3'd5;

   // Response status codes
   localparam logic [STATUS_W-1:0] STS_DONE        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_EXISTS      = 3'd1;
   localparam logic [STATUS_W-1:0] STS_MISSING     = 3'd2;
   localparam logic [STATUS_W-1:0] STS_EDGE_EXISTS = 3'd3;
   localparam logic [STATUS_W-1:0] STS_CYCLE       = 3'd4;
   localparam logic [STATUS_W-1:0] STS_PARENT_OFF  = 3'd5;

endpackage

// ===== rtl/dagt_walk_unit.sv =====
// Graph walk step unit: picks the lowest pending node and merges a fetched
// adjacency row back into the pending set.
// Depends on dagt_pkg.
module dagt_walk_unit
   import dagt_pkg::*;
#(
   parameter int NODE_COUNT = DEFAULT_NODE_COUNT
) (
   input  logic [NODE_COUNT-1:0]                      pend,
   input  logic [NODE_COUNT-1:0]                      seen,
   input  logic [NODE_COUNT-1:0]                      enabled,
   input  logic [NODE_COUNT-1:0]                      row,
   input  logic                                       dis_walk,
   output logic [((NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1)-1:0] pick_ix,
   output logic [NODE_COUNT-1:0]                      pick_bit,
   output logic                                       pend_empty,
   output logic [NODE_COUNT-1:0]                      pend_merged
);

   localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

   logic [IW-1:0]         ix;
   logic [NODE_COUNT-1:0] follow_mask;

   // Isolate the lowest set bit, then encode it (bits are one-hot)
   assign pick_bit   = pend & (~pend + NODE_COUNT'(1));
   assign pend_empty = (pend == '0);

   always_comb begin
      ix = '0;
      for (int i = 0; i < NODE_COUNT; i++) begin
         if (pick_bit[i]) begin
            ix = ix | IW'(i);
         end
      end
   end

   assign pick_ix = ix;

   // Disable walks only descend through nodes still enabled
   assign follow_mask = dis_walk ? enabled : '1;
   assign pend_merged = pend | (row & ~seen & follow_mask);

endmodule

// ===== rtl/dag_dependency_enable_tracker_unit.sv =====
// Dependency tracker over a directed acyclic graph of indexed nodes.
// Requests (req_action, req_node, req_child) transfer on req_valid & req_ready;
// one response (rsp_status, rsp_node_enabled, rsp_enabled_nodes,
// rsp_child_nodes) per request transfers on rsp_valid & rsp_ready.
// One request is processed at a time; req_ready is high while the sequencer
// is idle, also while an earlier response still waits in the output register.
// A request passes from transfer through the decode, response read and
// response output states to the response register; add edge and disable
// first walk the graph, with a read and a merge state per reached node, and
// enable first scans parent rows, with a read and a check state per row. The
// adjacency memory has a single registered read port.
// A new request is taken the cycle after the response is loaded.
// If the receiver stalls, a finished response holds the sequencer until the
// output register frees up; nothing is dropped.
// Synchronous reset clears the node, enable and walk masks and the response
// valid; adjacency rows need no clearing since adding a node clears its row.
// Depends on dagt_pkg and dagt_walk_unit.
module dag_dependency_enable_tracker_unit
   import dagt_pkg::*;
#(
   parameter int NODE_COUNT = DEFAULT_NODE_COUNT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [INDEX_W-1:0]  req_node,
   input  logic [INDEX_W-1:0]  req_child,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_node_enabled,
   output logic [MASK_W-1:0]   rsp_enabled_nodes,
   output logic [MASK_W-1:0]   rsp_child_nodes
);

   localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam logic [IW-1:0] LAST_IX = IW'(NODE_COUNT - 1);

   // Sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DECODE   = 3'd1;
   localparam logic [2:0] ST_WALK_RD  = 3'd2;
   localparam logic [2:0] ST_WALK_USE = 3'd3;
   localparam logic [2:0] ST_EN_RD    = 3'd4;
   localparam logic [2:0] ST_EN_CHK   = 3'd5;
   localparam logic [2:0] ST_RSP_RD   = 3'd6;
   localparam logic [2:0] ST_RSP_OUT  = 3'd7;

   typedef logic [NODE_COUNT-1:0] mask_type;

   // Control registers
   logic [2:0]          state_ff, state_in;
   mask_type            present_ff, present_in;
   mask_type            enabled_ff, enabled_in;
   mask_type            pend_ff, pend_in;
   mask_type            seen_ff, seen_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Request and work registers
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [INDEX_W-1:0]  node_ff, node_in;
   logic [INDEX_W-1:0]  child_ff, child_in;
   logic                dis_ff, dis_in;
   logic [IW-1:0]       scan_ff, scan_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   mask_type            node_row_ff, node_row_in;

   // Response registers
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_node_enabled_ff;
   logic [MASK_W-1:0]   rsp_enabled_nodes_ff;
   logic [MASK_W-1:0]   rsp_child_nodes_ff;

   // Adjacency memory: one row of child bits per node
   mask_type            adj_rows_ff [NODE_COUNT];
   mask_type            row_rd_ff;
   logic [IW-1:0]       mem_rd_ix;
   logic                mem_we;
   logic [IW-1:0]       mem_wr_ix;
   mask_type            mem_wr_data;

   // Decoded request fields
   logic [IW-1:0]       node_ix, child_ix;
   mask_type            node_bit, child_bit;
   logic                node_in_range, child_in_range;
   logic                node_present, child_present;
   logic                req_xfer, rsp_load;

   // Walk unit outputs
   logic [IW-1:0]       pick_ix;
   mask_type            pick_bit;
   logic                pend_empty;
   mask_type            pend_merged;

   assign node_ix        = IW'(node_ff);
   assign child_ix       = IW'(child_ff);
   assign node_bit       = mask_type'(1) << node_ix;
   assign child_bit      = mask_type'(1) << child_ix;
   assign node_in_range  = (int'(node_ff) < NODE_COUNT);
   assign child_in_range = (int'(child_ff) < NODE_COUNT);
   assign node_present   = node_in_range && present_ff[node_ix];
   assign child_present  = child_in_range && present_ff[child_ix];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   dagt_walk_unit #(
      .NODE_COUNT (NODE_COUNT)
   ) u_walk (
      .pend        (pend_ff),
      .seen        (seen_ff),
      .enabled     (enabled_ff),
      .row         (row_rd_ff),
      .dis_walk    (dis_ff),
      .pick_ix     (pick_ix),
      .pick_bit    (pick_bit),
      .pend_empty  (pend_empty),
      .pend_merged (pend_merged)
   );

   // Sequencer next state and datapath
   always_comb begin
      state_in     = state_ff;
      present_in   = present_ff;
      enabled_in   = enabled_ff;
      pend_in      = pend_ff;
      seen_in      = seen_ff;
      action_in    = action_ff;
      node_in      = node_ff;
      child_in     = child_ff;
      dis_in       = dis_ff;
      scan_in      = scan_ff;
      status_in    = status_ff;
      node_row_in  = node_row_ff;
      mem_rd_ix    = node_ix;
      mem_we       = 1'b0;
      mem_wr_ix    = node_ix;
      mem_wr_data  = '0;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // fetch the addressed row while the request is captured
            mem_rd_ix = IW'(req_node);
            if (req_xfer) begin
               action_in = req_action;
               node_in   = req_node;
               child_in  = req_child;
               state_in  = ST_DECODE;
            end
         end

         ST_DECODE: begin
            node_row_in = row_rd_ff;
            status_in   = STS_DONE;
            state_in    = ST_RSP_RD;
            if (action_ff == ACT_ADD_NODE) begin
               if (!node_in_range) begin
                  status_in = STS_MISSING;
               end else if (present_ff[node_ix]) begin
                  status_in = STS_EXISTS;
               end else begin
                  present_in  = present_ff | node_bit;
                  enabled_in  = enabled_ff | node_bit;
                  mem_we      = 1'b1;
                  mem_wr_data = '0;
               end
            end else if (!node_present) begin
               status_in = STS_MISSING;
            end else begin
               case (action_ff)
                  ACT_ADD_EDGE: begin
                     if (!child_present) begin
                        status_in = STS_MISSING;
                     end else if ((row_rd_ff & child_bit) != '0) begin
                        status_in = STS_EDGE_EXISTS;
                     end else begin
                        // reachability walk from the child
                        pend_in  = child_bit;
                        seen_in  = '0;
                        dis_in   = 1'b0;
                        state_in = ST_WALK_RD;
                     end
                  end
                  ACT_ENABLE: begin
                     scan_in  = '0;
                     state_in = ST_EN_RD;
                  end
                  ACT_DISABLE: begin
                     pend_in  = node_bit & enabled_ff;
                     seen_in  = '0;
                     dis_in   = 1'b1;
                     state_in = ST_WALK_RD;
                  end
                  ACT_TOGGLE: begin
                     if (enabled_ff[node_ix]) begin
                        pend_in  = node_bit;
                        seen_in  = '0;
                        dis_in   = 1'b1;
                        state_in = ST_WALK_RD;
                     end else begin
                        scan_in  = '0;
                        state_in = ST_EN_RD;
                     end
                  end
                  default: begin
                     status_in = STS_DONE;
                  end
               endcase
            end
         end

         ST_WALK_RD: begin
            // take the lowest pending node and fetch its row
            mem_rd_ix = pick_ix;
            if (pend_empty) begin
               state_in = ST_RSP_RD;
               if (!dis_ff) begin
                  if ((seen_ff & node_bit) != '0) begin
                     status_in = STS_CYCLE;
                  end else begin
                     mem_we      = 1'b1;
                     mem_wr_data = node_row_ff | child_bit;
                  end
               end
            end else begin
               pend_in = pend_ff & ~pick_bit;
               seen_in = seen_ff | pick_bit;
               if (dis_ff) begin
                  enabled_in = enabled_ff & ~pick_bit;
               end
               state_in = ST_WALK_USE;
            end
         end

         ST_WALK_USE: begin
            pend_in  = pend_merged;
            state_in = ST_WALK_RD;
         end

         ST_EN_RD: begin
            mem_rd_ix = scan_ff;
            state_in  = ST_EN_CHK;
         end

         ST_EN_CHK: begin
            // a present, disabled parent blocks the enable
            if (present_ff[scan_ff] && ((row_rd_ff & node_bit) != '0)
                && !enabled_ff[scan_ff]) begin
               status_in = STS_PARENT_OFF;
               state_in  = ST_RSP_RD;
            end else if (scan_ff == LAST_IX) begin
               enabled_in = enabled_ff | node_bit;
               state_in   = ST_RSP_RD;
            end else begin
               scan_in  = scan_ff + IW'(1);
               state_in = ST_EN_RD;
            end
         end

         ST_RSP_RD: begin
            mem_rd_ix = node_ix;
            pend_in   = '0;
            seen_in   = '0;
            state_in  = ST_RSP_OUT;
         end

         ST_RSP_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         present_ff   <= '0;
         enabled_ff   <= '0;
         pend_ff      <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         enabled_ff   <= enabled_in;
         pend_ff      <= pend_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Work registers
   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      node_ff     <= node_in;
      child_ff    <= child_in;
      dis_ff      <= dis_in;
      scan_ff     <= scan_in;
      status_ff   <= status_in;
      node_row_ff <= node_row_in;
   end

   // Adjacency memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         adj_rows_ff[mem_wr_ix] <= mem_wr_data;
      end
      row_rd_ff <= adj_rows_ff[mem_rd_ix];
   end

   // Response register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff        <= status_ff;
         rsp_node_enabled_ff  <= node_present && enabled_ff[node_ix];
         rsp_enabled_nodes_ff <= MASK_W'(enabled_ff & present_ff);
         rsp_child_nodes_ff   <= node_present ? MASK_W'(row_rd_ff) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_node_enabled  = rsp_node_enabled_ff;
   assign rsp_enabled_nodes = rsp_enabled_nodes_ff;
   assign rsp_child_nodes   = rsp_child_nodes_ff;

   // Only present nodes may be enabled
   a_enabled_present: assert property (@(posedge clock) disable iff (reset)
      (enabled_ff & ~present_ff) == '0)
      else $error("enabled node not present");

   // Walk registers are clear whenever the sequencer is idle
   a_idle_walk_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (pend_ff == '0 && seen_ff == '0))
      else $error("walk state left over in idle");

   // A request transfer always starts decoding
   a_xfer_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECODE))
      else $error("request transfer did not start decode");

   // A new response only comes out of the response state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RSP_OUT))
      else $error("response loaded outside response state");

endmodule
